>>> rtl/mhtq_pkg.sv
package mhtq_pkg;

    typedef struct packed {
        logic [31:0] deadline;
        logic [31:0] ident;
        logic [31:0] owner;
        logic [31:0] handle;
    } entry_t;

    localparam logic [1:0] OP_ADD  = 2'd0;
    localparam logic [1:0] OP_DEL  = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_DEL    = 2'd1;
    localparam logic [1:0] KIND_EXPIRE = 2'd2;
    localparam logic [1:0] KIND_TICK   = 2'd3;

    localparam logic [31:0] IDLE_DELAY_RESET = 32'd1000000;
    localparam logic [5:0]  MAX_EXPIRE       = 6'd63;

endpackage

>>> rtl/min_heap_timer_queue_unit.sv
// channel | dir | tdata (low bit up)                              | tuser / tlast
// s_      | in  | service, delay_ms, callback_tag, timer_id, now_ms | opcode / -
// m_      | out | result_id, result_service, result_tag, next_delay | kind, status,
//         |     |                                                   | queue_empty / last
// cfg_    | in  | idle_delay, written when cfg_wr_en is high        |
// one item at a time: s_tready is high only while the sequencer idles.
// heap entries live in one single-port-read memory, not cleared by aresetn; a sift level up
// reads parent then compares; a level down reads left, then right if present, then compares.
// delete scans ids slot by slot, reading then checking each, before its removal.
// aresetn (synchronous) clears count, time, id counter; idle_delay gets IDLE_DELAY_RESET.
// the sequencer holds while the output register is full and not taken.
module min_heap_timer_queue_unit #(
    parameter int CAPACITY = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [31:0]  cfg_wr_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // service, delay_ms, callback_tag, timer_id, now_ms
    input  logic [159:0] s_tdata,
    // opcode
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // result_id, result_service, result_tag, next_delay
    output logic [127:0] m_tdata,
    // kind, status, queue_empty
    output logic [3:0]   m_tuser,
    output logic         m_tlast
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = IW + 2;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_UP      = 4'd1;
    localparam logic [3:0] ST_UP_CMP  = 4'd2;
    localparam logic [3:0] ST_DN      = 4'd3;
    localparam logic [3:0] ST_DN_L    = 4'd4;
    localparam logic [3:0] ST_DN_R    = 4'd5;
    localparam logic [3:0] ST_DN_CMP  = 4'd6;
    localparam logic [3:0] ST_DEL_RD  = 4'd7;
    localparam logic [3:0] ST_DEL_CHK = 4'd8;
    localparam logic [3:0] ST_REM_RD  = 4'd9;
    localparam logic [3:0] ST_REM_LD  = 4'd10;
    localparam logic [3:0] ST_TICK    = 4'd11;
    localparam logic [3:0] ST_TICK_CHK = 4'd12;
    localparam logic [3:0] ST_FIN     = 4'd13;

    mhtq_pkg::entry_t heap_mem [CAPACITY];
    mhtq_pkg::entry_t rd_data_reg;

    logic [3:0]   state_reg, state_next;
    logic [1:0]   op_reg, op_next;
    mhtq_pkg::entry_t ent_reg, ent_next;
    mhtq_pkg::entry_t child_reg, child_next;
    logic [IW-1:0] p_reg, p_next;
    logic [IW-1:0] pos_reg, pos_next;
    logic [IW-1:0] cidx_reg, cidx_next;
    logic [CW-1:0] scan_reg, scan_next;
    logic [CW-1:0] count_reg, count_next;
    logic [31:0]  time_reg, time_next;
    logic [31:0]  idc_reg, idc_next;
    logic [31:0]  idle_reg, idle_next;
    logic [31:0]  tid_reg, tid_next;
    logic [31:0]  rid_reg, rid_next;
    logic [5:0]   nexp_reg, nexp_next;
    logic         status_reg, status_next;
    logic         m_valid_reg, m_valid_next;
    logic [127:0] m_data_reg, m_data_next;
    logic [3:0]   m_user_reg, m_user_next;
    logic         m_last_reg, m_last_next;

    logic          mem_we;
    logic [IW-1:0] mem_wa;
    mhtq_pkg::entry_t mem_wd;
    logic          rd_en;
    logic [IW-1:0] rd_addr;

    logic          out_free;
    logic [XW-1:0] left_x, right_x, count_x;
    logic [IW-1:0] parent;

    assign out_free = !m_valid_reg || m_tready;
    assign left_x   = {1'b0, p_reg, 1'b1};
    assign right_x  = left_x + XW'(1);
    assign count_x  = XW'(count_reg);
    assign parent   = (p_reg - IW'(1)) >> 1;

    assign s_tready = aresetn && (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            heap_mem[mem_wa] <= mem_wd;
        end
        if (rd_en) begin
            rd_data_reg <= heap_mem[rd_addr];
        end
    end

    always_comb begin
        state_next  = state_reg;
        op_next     = op_reg;
        ent_next    = ent_reg;
        child_next  = child_reg;
        p_next      = p_reg;
        pos_next    = pos_reg;
        cidx_next   = cidx_reg;
        scan_next   = scan_reg;
        count_next  = count_reg;
        time_next   = time_reg;
        idc_next    = idc_reg;
        idle_next   = cfg_wr_en ? cfg_wr_data : idle_reg;
        tid_next    = tid_reg;
        rid_next    = rid_reg;
        nexp_next   = nexp_reg;
        status_next = status_reg;
        m_valid_next = m_tready ? 1'b0 : m_valid_reg;
        m_data_next = m_data_reg;
        m_user_next = m_user_reg;
        m_last_next = m_last_reg;
        mem_we  = 1'b0;
        mem_wa  = p_reg;
        mem_wd  = ent_reg;
        rd_en   = 1'b0;
        rd_addr = p_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next = s_tuser;
                    case (s_tuser)
                        mhtq_pkg::OP_ADD: begin
                            if (count_reg >= CAP_C) begin
                                status_next = 1'b1;
                                rid_next    = '0;
                                state_next  = ST_FIN;
                            end else begin
                                ent_next.deadline = time_reg + s_tdata[63:32];
                                ent_next.ident    = idc_reg;
                                ent_next.owner    = s_tdata[31:0];
                                ent_next.handle   = s_tdata[95:64];
                                status_next = 1'b0;
                                rid_next    = idc_reg;
                                idc_next    = idc_reg + 32'd1;
                                p_next      = count_reg[IW-1:0];
                                count_next  = count_reg + CW'(1);
                                state_next  = ST_UP;
                            end
                        end
                        mhtq_pkg::OP_DEL: begin
                            tid_next    = s_tdata[127:96];
                            scan_next   = '0;
                            status_next = 1'b0;
                            rid_next    = '0;
                            state_next  = ST_DEL_RD;
                        end
                        mhtq_pkg::OP_TICK: begin
                            time_next  = s_tdata[159:128];
                            nexp_next  = '0;
                            state_next = ST_TICK;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_UP: begin
                if (p_reg == '0) begin
                    mem_we     = 1'b1;
                    state_next = ST_FIN;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = parent;
                    state_next = ST_UP_CMP;
                end
            end
            ST_UP_CMP: begin
                mem_we = 1'b1;
                if (ent_reg.deadline < rd_data_reg.deadline) begin
                    mem_wd     = rd_data_reg;
                    p_next     = parent;
                    state_next = ST_UP;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_DN: begin
                if (left_x >= count_x) begin
                    if (p_reg > pos_reg) begin
                        mem_we     = 1'b1;
                        state_next = ST_FIN;
                    end else begin
                        state_next = ST_UP;
                    end
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = left_x[IW-1:0];
                    state_next = ST_DN_L;
                end
            end
            ST_DN_L: begin
                child_next = rd_data_reg;
                cidx_next  = left_x[IW-1:0];
                if (right_x < count_x) begin
                    rd_en      = 1'b1;
                    rd_addr    = right_x[IW-1:0];
                    state_next = ST_DN_R;
                end else begin
                    state_next = ST_DN_CMP;
                end
            end
            ST_DN_R: begin
                // equal children: the right one wins
                if (!(child_reg.deadline < rd_data_reg.deadline)) begin
                    child_next = rd_data_reg;
                    cidx_next  = right_x[IW-1:0];
                end
                state_next = ST_DN_CMP;
            end
            ST_DN_CMP: begin
                if (child_reg.deadline < ent_reg.deadline) begin
                    mem_we     = 1'b1;
                    mem_wd     = child_reg;
                    p_next     = cidx_reg;
                    state_next = ST_DN;
                end else if (p_reg > pos_reg) begin
                    mem_we     = 1'b1;
                    state_next = ST_FIN;
                end else begin
                    state_next = ST_UP;
                end
            end
            ST_DEL_RD: begin
                if (scan_reg >= count_reg) begin
                    status_next = 1'b1;
                    state_next  = ST_FIN;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = scan_reg[IW-1:0];
                    state_next = ST_DEL_CHK;
                end
            end
            ST_DEL_CHK: begin
                if (rd_data_reg.ident == tid_reg) begin
                    count_next = count_reg - CW'(1);
                    pos_next   = scan_reg[IW-1:0];
                    p_next     = scan_reg[IW-1:0];
                    state_next = (scan_reg == count_reg - CW'(1)) ? ST_FIN : ST_REM_RD;
                end else begin
                    scan_next  = scan_reg + CW'(1);
                    state_next = ST_DEL_RD;
                end
            end
            ST_REM_RD: begin
                // count already points at the former last slot
                rd_en      = 1'b1;
                rd_addr    = count_reg[IW-1:0];
                state_next = ST_REM_LD;
            end
            ST_REM_LD: begin
                ent_next   = rd_data_reg;
                state_next = ST_DN;
            end
            ST_TICK: begin
                if (count_reg == '0) begin
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        m_data_next  = {idle_reg, 96'd0};
                        m_user_next  = {1'b1, 1'b0, mhtq_pkg::KIND_TICK};
                        m_last_next  = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = '0;
                    state_next = ST_TICK_CHK;
                end
            end
            ST_TICK_CHK: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (nexp_reg < mhtq_pkg::MAX_EXPIRE &&
                        !(time_reg < rd_data_reg.deadline)) begin
                        m_data_next = {32'd0, rd_data_reg.handle, rd_data_reg.owner,
                                       rd_data_reg.ident};
                        m_user_next = {(count_reg == CW'(1)), 1'b0, mhtq_pkg::KIND_EXPIRE};
                        m_last_next = 1'b0;
                        nexp_next   = nexp_reg + 6'd1;
                        count_next  = count_reg - CW'(1);
                        pos_next    = '0;
                        p_next      = '0;
                        state_next  = (count_reg == CW'(1)) ? ST_FIN : ST_REM_RD;
                    end else begin
                        m_data_next = {rd_data_reg.deadline - time_reg, 96'd0};
                        m_user_next = {1'b0, 1'b0, mhtq_pkg::KIND_TICK};
                        m_last_next = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end
            end
            ST_FIN: begin
                if (op_reg == mhtq_pkg::OP_TICK) begin
                    state_next = ST_TICK;
                end else if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {96'd0, rid_reg};
                    m_user_next  = {(count_reg == '0), status_reg,
                                    (op_reg == mhtq_pkg::OP_ADD) ? mhtq_pkg::KIND_ADD
                                                                 : mhtq_pkg::KIND_DEL};
                    m_last_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            time_reg    <= '0;
            idc_reg     <= '0;
            idle_reg    <= mhtq_pkg::IDLE_DELAY_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            time_reg    <= time_next;
            idc_reg     <= idc_next;
            idle_reg    <= idle_next;
            m_valid_reg <= m_valid_next;
        end
        op_reg     <= op_next;
        ent_reg    <= ent_next;
        child_reg  <= child_next;
        p_reg      <= p_next;
        pos_reg    <= pos_next;
        cidx_reg   <= cidx_next;
        scan_reg   <= scan_next;
        tid_reg    <= tid_next;
        rid_reg    <= rid_next;
        nexp_reg   <= nexp_next;
        status_reg <= status_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
        m_last_reg <= m_last_next;
    end

endmodule

>>> tb/tb_min_heap_timer_queue_unit.sv
module tb_min_heap_timer_queue_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP = 32;
    // opcode with no meaning, dropped by the block
    localparam logic [1:0] OP_IGNORED = 2'd3;

    typedef struct {
        logic [1:0]  kind;
        logic        status;
        logic [31:0] id;
        logic [31:0] service;
        logic [31:0] tag;
        logic [31:0] next_delay;
        logic        empty;
        logic        last;
    } outcome_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_wr_en = 1'b0;
    logic [31:0]  cfg_wr_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    // service, delay_ms, callback_tag, timer_id, now_ms
    logic [159:0] s_tdata = '0;
    // opcode
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // result_id, result_service, result_tag, next_delay
    logic [127:0] m_tdata;
    // kind, status, queue_empty
    logic [3:0]   m_tuser;
    logic         m_tlast;

    min_heap_timer_queue_unit #(.CAPACITY(CAP)) dut (.*);

    initial forever #5 aclk = ~aclk;

    // shadow copy of the timer heap
    logic [31:0] q_deadline [CAP];
    logic [31:0] q_id [CAP];
    logic [31:0] q_owner [CAP];
    logic [31:0] q_tag [CAP];
    int unsigned q_count;
    logic [31:0] q_now, q_next_id, q_idle;
    logic [31:0] live_ids [$];

    outcome_t pending [$];
    int errors = 0;
    bit calm = 0;

    function automatic void swap_entries(int a, int b);
        logic [31:0] t;
        t = q_deadline[a]; q_deadline[a] = q_deadline[b]; q_deadline[b] = t;
        t = q_id[a]; q_id[a] = q_id[b]; q_id[b] = t;
        t = q_owner[a]; q_owner[a] = q_owner[b]; q_owner[b] = t;
        t = q_tag[a]; q_tag[a] = q_tag[b]; q_tag[b] = t;
    endfunction

    function automatic void bubble_up(int p);
        int parent;
        while (p > 0) begin
            parent = (p - 1) / 2;
            if (!(q_deadline[p] < q_deadline[parent])) break;
            swap_entries(p, parent);
            p = parent;
        end
    endfunction

    function automatic bit bubble_down(int p);
        int i, l, pick;
        i = p;
        forever begin
            l = 2 * i + 1;
            if (l >= q_count) break;
            pick = l;
            if (l + 1 < q_count && !(q_deadline[l] < q_deadline[l + 1])) pick = l + 1;
            if (!(q_deadline[pick] < q_deadline[i])) break;
            swap_entries(i, pick);
            i = pick;
        end
        return i > p;
    endfunction

    function automatic void take_slot(int i);
        int lastpos;
        lastpos = q_count - 1;
        q_count = lastpos;
        if (i != lastpos) begin
            q_deadline[i] = q_deadline[lastpos];
            q_id[i] = q_id[lastpos];
            q_owner[i] = q_owner[lastpos];
            q_tag[i] = q_tag[lastpos];
            if (!bubble_down(i)) bubble_up(i);
        end
    endfunction

    function automatic void push_outcome(logic [1:0] k, logic st, logic [31:0] id,
                                         logic [31:0] svc, logic [31:0] tg,
                                         logic [31:0] nd, logic lst);
        outcome_t o;
        o.kind = k; o.status = st; o.id = id; o.service = svc; o.tag = tg;
        o.next_delay = nd; o.empty = (q_count == 0); o.last = lst;
        pending.insert(pending.size(), o);
    endfunction

    function automatic void predict_timers(logic [1:0] op, logic [31:0] svc,
                                           logic [31:0] dly, logic [31:0] tg,
                                           logic [31:0] tid, logic [31:0] now);
        int n;
        bit found;
        case (op)
            mhtq_pkg::OP_ADD: begin
                if (q_count >= CAP) begin
                    push_outcome(mhtq_pkg::KIND_ADD, 1'b1, '0, '0, '0, '0, 1'b1);
                end else begin
                    q_deadline[q_count] = q_now + dly;
                    q_id[q_count] = q_next_id;
                    q_owner[q_count] = svc;
                    q_tag[q_count] = tg;
                    q_count++;
                    bubble_up(q_count - 1);
                    live_ids.insert(live_ids.size(), q_next_id);
                    push_outcome(mhtq_pkg::KIND_ADD, 1'b0, q_next_id, '0, '0, '0, 1'b1);
                    q_next_id++;
                end
            end
            mhtq_pkg::OP_DEL: begin
                found = 0;
                for (int i = 0; i < q_count; i++) begin
                    if (q_id[i] == tid) begin
                        take_slot(i);
                        found = 1;
                        break;
                    end
                end
                push_outcome(mhtq_pkg::KIND_DEL, !found, '0, '0, '0, '0, 1'b1);
            end
            mhtq_pkg::OP_TICK: begin
                n = 0;
                q_now = now;
                while (q_count > 0 && n < 63 && !(now < q_deadline[0])) begin
                    logic [31:0] eid, esv, etg;
                    eid = q_id[0]; esv = q_owner[0]; etg = q_tag[0];
                    take_slot(0);
                    push_outcome(mhtq_pkg::KIND_EXPIRE, 1'b0, eid, esv, etg, '0, 1'b0);
                    n++;
                end
                push_outcome(mhtq_pkg::KIND_TICK, 1'b0, '0, '0, '0,
                             q_count > 0 ? q_deadline[0] - now : q_idle, 1'b1);
            end
            default: ;
        endcase
    endfunction

    // tvalid stays high after an accept so items can follow back to back
    task automatic send_item(logic [1:0] op, logic [31:0] svc, logic [31:0] dly,
                             logic [31:0] tg, logic [31:0] tid, logic [31:0] now);
        while (!calm && $urandom_range(99) < 36) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {now, tid, tg, dly, svc};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_timers(op, svc, dly, tg, tid, now);
    endtask

    task automatic add_timer(logic [31:0] dly);
        send_item(mhtq_pkg::OP_ADD, $urandom, dly, $urandom, $urandom, $urandom);
    endtask

    task automatic delete_timer(logic [31:0] tid);
        send_item(mhtq_pkg::OP_DEL, $urandom, $urandom, $urandom, tid, $urandom);
    endtask

    task automatic tick(logic [31:0] now);
        send_item(mhtq_pkg::OP_TICK, $urandom, $urandom, $urandom, $urandom, now);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic set_idle_delay(logic [31:0] v);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        q_idle = v;
    endtask

    // output side: random stalls, checked against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (pending.size() == 0) begin
                    $display("%0t: unexpected item kind=%0d data=%h", $time,
                             m_tuser[1:0], m_tdata);
                    errors++;
                end else begin
                    outcome_t e;
                    e = pending.pop_front();
                    if (m_tuser[1:0] !== e.kind || m_tuser[2] !== e.status ||
                        m_tuser[3] !== e.empty || m_tlast !== e.last ||
                        m_tdata[31:0] !== e.id || m_tdata[63:32] !== e.service ||
                        m_tdata[95:64] !== e.tag || m_tdata[127:96] !== e.next_delay) begin
                        $display("%0t: mismatch expected kind=%0d st=%0d empty=%0d last=%0d",
                                 $time, e.kind, e.status, e.empty, e.last,
                                 " id=%h svc=%h tag=%h nd=%h", e.id, e.service, e.tag,
                                 e.next_delay);
                        $display("%0t:          actual kind=%0d st=%0d empty=%0d last=%0d",
                                 $time, m_tuser[1:0], m_tuser[2], m_tuser[3], m_tlast,
                                 " id=%h svc=%h tag=%h nd=%h", m_tdata[31:0],
                                 m_tdata[63:32], m_tdata[95:64], m_tdata[127:96]);
                        errors++;
                    end
                end
            end
        end
        m_tready <= calm || ($urandom_range(99) >= 36);
    end

    task automatic test_directed();
        tick(32'd0);
        delete_timer(32'd0);
        add_timer(32'd0);
        add_timer(32'hFFFF_FFFF);
        add_timer(32'd5);
        add_timer(32'd5);
        send_item(OP_IGNORED, '1, '1, '1, '1, '1);
        send_item(mhtq_pkg::OP_ADD, 32'hFFFF_FFFF, 32'd7, 32'hFFFF_FFFF, 32'd0, 32'd0);
        send_item(mhtq_pkg::OP_ADD, 32'd0, 32'd7, 32'd0, 32'd0, 32'd0);
        delete_timer(32'd2);
        delete_timer(32'hFFFF_FFFF);
        tick(32'd5);
        tick(32'd7);
        tick(32'hFFFF_FFFE);
        tick(32'hFFFF_FFFF);
        tick(32'hFFFF_FFFF);
    endtask

    task automatic test_full_heap();
        for (int i = 0; i < CAP + 2; i++) add_timer($urandom_range(1000, 1));
        delete_timer(live_ids[live_ids.size() - 1]);
        add_timer(32'd3);
        add_timer(32'd3);
        // pause until the whole heap has answered before draining it
        wait_drained();
        tick(32'hFFFF_FFFF);
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++) begin
            int r;
            r = $urandom_range(99);
            if (i == count / 2) calm = 1;
            if (i == count / 2 + 60) calm = 0;
            if (r < 45) add_timer($urandom_range(9) == 0 ? $urandom : $urandom_range(500));
            else if (r < 65) delete_timer((live_ids.size() > 0 && $urandom_range(3) != 0)
                                          ? live_ids[$urandom_range(live_ids.size() - 1)]
                                          : $urandom);
            else if (r < 95) tick(q_now + $urandom_range(150));
            else if (r < 97) tick($urandom);
            else send_item(OP_IGNORED, $urandom, $urandom, $urandom, $urandom, $urandom);
        end
    endtask

    initial begin
        q_count = 0; q_now = '0; q_next_id = '0; q_idle = mhtq_pkg::IDLE_DELAY_RESET;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        set_idle_delay(32'd0);
        test_full_heap();
        set_idle_delay(32'hFFFF_FFFF);
        test_random(130);
        set_idle_delay($urandom);
        test_random(140);
        wait_drained();
        if (errors == 0) $display("Test completed successfully");
        else $display("Test completed with failures");
        $finish;
    end

    initial begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end
endmodule
